// ===== rtl/ps2_host_side_port_unit_macros.svh =====
// Assertion helpers used by the queue RTL.
`ifndef PS2_HOST_SIDE_PORT_UNIT_MACROS_SVH
`define PS2_HOST_SIDE_PORT_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PS2HP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2hp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PS2HP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2hp assertion failed");

`endif

// ===== rtl/ps2hp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ps2hp_pkg;

   typedef enum logic [1:0] {
      CMD_EDGE  = 2'd0,
      CMD_SEND  = 2'd1,
      CMD_POP   = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic {
      CSR_MIN_INTERVAL = 1'b0,
      CSR_MAX_INTERVAL = 1'b1
   } csr_index_type;

   localparam logic [7:0] MIN_INTERVAL_RESET = 8'd56;
   localparam logic [7:0] MAX_INTERVAL_RESET = 8'd104;

   // Receive bit positions: start at 0, data at 1..8, parity at 9, stop after.
   localparam logic [3:0] RX_PARITY_BIT = 4'd9;
   // Transmit bit positions: data at 0..7, parity at 8, stop at 9, end after.
   localparam logic [3:0] TX_PARITY_BIT = 4'd8;
   localparam logic [3:0] TX_STOP_BIT   = 4'd9;

   typedef struct packed {
      logic       store;
      logic [7:0] data;
   } frame_type;

   typedef struct packed {
      logic       store;
      logic [7:0] data;
      logic       pop;
      logic       clear;
   } queue_op_type;

   typedef struct packed {
      logic       rd_valid;
      logic       stored;
      logic       dropped;
      logic [3:0] fill;
   } queue_status_type;

endpackage
`default_nettype wire

// ===== rtl/ps2hp_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ps2hp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic       data_pin;
   logic [7:0] interval_ticks;
   logic [7:0] tx_byte;

   modport source (output valid, output cmd, output data_pin, output interval_ticks,
                   output tx_byte, input ready);
   modport sink (input valid, input cmd, input data_pin, input interval_ticks,
                 input tx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/ps2hp_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ps2hp_rsp_if;
   logic       valid;
   logic       ready;
   logic       data_drive;
   logic       busy_res;
   logic [7:0] rx_byte;
   logic       rx_valid;
   logic [3:0] fill_count;
   logic       frame_stored;
   logic       dropped_oldest;

   modport source (output valid, output data_drive, output busy_res, output rx_byte,
                   output rx_valid, output fill_count, output frame_stored,
                   output dropped_oldest, input ready);
   modport sink (input valid, input data_drive, input busy_res, input rx_byte,
                 input rx_valid, input fill_count, input frame_stored,
                 input dropped_oldest, output ready);
endinterface
`default_nettype wire

// ===== rtl/ps2_host_side_port_unit.sv =====
// Host-side PS/2 port.
// The req channel carries one command per transfer: a falling edge of the
// device clock (with the sampled data pin and the tick count since the last
// edge), a send request, a pop from the receive queue, or a queue clear.
// Every request transfer produces exactly one rsp transfer with the data line
// control, the busy flag, the popped byte, the queue fill and frame status.
// Rsp valid rises in the cycle after the req transfer. One request is
// taken every cycle, limited only by the single result register: req ready is
// high while that register is empty or being taken in the same cycle.
// When the receiver stalls rsp, the result holds and req ready drops until it
// is taken, so no link, queue or result state changes meanwhile.
// The receive queue is a RAM with registered read, read at the tail pointer
// when a pop finds data; one entry is always left free, so it holds at most
// QUEUE_DEPTH-1 bytes and overwrites the oldest byte when full.
// Reset empties the queue, releases the data line, stops any send or receive
// and loads the interval window with 56 and 104 ticks; no clearing pass runs.
// The user must write the window limits via the csr port only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module ps2_host_side_port_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   ps2hp_req_if.sink        req_port,
   ps2hp_rsp_if.source      rsp_port,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic [7:0] min_interval_ff;
   logic [7:0] max_interval_ff;

   logic                        accept;
   ps2hp_pkg::cmd_type          cmd;
   ps2hp_pkg::frame_type        frame;
   ps2hp_pkg::queue_op_type     queue_op;
   ps2hp_pkg::queue_status_type queue_status;
   logic                        line_level_in;
   logic                        sending_in;
   logic [7:0]                  rd_data;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       data_drive_ff;
   logic       busy_ff;
   logic       rx_valid_ff;
   logic [3:0] fill_ff;
   logic       stored_ff;
   logic       dropped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff <= ps2hp_pkg::MIN_INTERVAL_RESET;
         max_interval_ff <= ps2hp_pkg::MAX_INTERVAL_RESET;
      end else if (csr_we) begin
         unique case (ps2hp_pkg::csr_index_type'(csr_index))
            ps2hp_pkg::CSR_MIN_INTERVAL: min_interval_ff <= csr_wdata;
            ps2hp_pkg::CSR_MAX_INTERVAL: max_interval_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;
   assign cmd            = ps2hp_pkg::cmd_type'(req_port.cmd);

   ps2hp_link u_link (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .cmd            (cmd),
      .data_pin       (req_port.data_pin),
      .interval_ticks (req_port.interval_ticks),
      .tx_byte        (req_port.tx_byte),
      .min_interval   (min_interval_ff),
      .max_interval   (max_interval_ff),
      .frame          (frame),
      .line_level_in  (line_level_in),
      .sending_in     (sending_in)
   );

   always_comb begin
      queue_op.store = frame.store;
      queue_op.data  = frame.data;
      queue_op.pop   = accept && (cmd == ps2hp_pkg::CMD_POP);
      queue_op.clear = accept && (cmd == ps2hp_pkg::CMD_CLEAR);
   end

   ps2hp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .op      (queue_op),
      .status  (queue_status),
      .rd_data (rd_data)
   );

   assign rsp_valid_in = req_port.ready ? accept : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_drive_ff <= line_level_in;
         busy_ff       <= sending_in;
         rx_valid_ff   <= queue_status.rd_valid;
         fill_ff       <= queue_status.fill;
         stored_ff     <= queue_status.stored;
         dropped_ff    <= queue_status.dropped;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.data_drive     = data_drive_ff;
   assign rsp_port.busy_res       = busy_ff;
   assign rsp_port.rx_byte        = rx_valid_ff ? rd_data : 8'd0;
   assign rsp_port.rx_valid       = rx_valid_ff;
   assign rsp_port.fill_count     = fill_ff;
   assign rsp_port.frame_stored   = stored_ff;
   assign rsp_port.dropped_oldest = dropped_ff;

endmodule
`default_nettype wire

// ===== rtl/ps2hp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ps2hp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ps2hp_link.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ps2hp_link (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire ps2hp_pkg::cmd_type  cmd,
   input  wire logic                data_pin,
   input  wire logic [7:0]          interval_ticks,
   input  wire logic [7:0]          tx_byte,
   input  wire logic [7:0]          min_interval,
   input  wire logic [7:0]          max_interval,
   output      ps2hp_pkg::frame_type frame,
   output      logic                line_level_in,
   output      logic                sending_in
);

   logic [3:0] bit_index_ff, bit_index_in;
   logic       parity_acc_ff, parity_acc_in;
   logic       parity_seen_ff, parity_seen_in;
   logic       sending_ff;
   logic       line_level_ff;
   logic [7:0] rx_shift_ff, rx_shift_in;
   logic [7:0] tx_shift_ff, tx_shift_in;
   logic       in_window;

   assign in_window = (interval_ticks >= min_interval) && (interval_ticks <= max_interval);

   always_comb begin
      bit_index_in   = bit_index_ff;
      parity_acc_in  = parity_acc_ff;
      parity_seen_in = parity_seen_ff;
      sending_in     = sending_ff;
      line_level_in  = line_level_ff;
      rx_shift_in    = rx_shift_ff;
      tx_shift_in    = tx_shift_ff;
      frame.store    = 1'b0;
      frame.data     = rx_shift_ff;
      if (accept) begin
         unique case (cmd)
            ps2hp_pkg::CMD_EDGE: begin
               if (sending_ff) begin
                  if (bit_index_ff < ps2hp_pkg::TX_PARITY_BIT) begin
                     line_level_in = tx_shift_ff[0];
                     parity_acc_in = parity_acc_ff ^ tx_shift_ff[0];
                     tx_shift_in   = {1'b0, tx_shift_ff[7:1]};
                     bit_index_in  = bit_index_ff + 4'd1;
                  end else if (bit_index_ff == ps2hp_pkg::TX_PARITY_BIT) begin
                     line_level_in = ~parity_acc_ff;
                     bit_index_in  = bit_index_ff + 4'd1;
                  end else if (bit_index_ff == ps2hp_pkg::TX_STOP_BIT) begin
                     line_level_in = 1'b1;
                     bit_index_in  = bit_index_ff + 4'd1;
                  end else begin
                     sending_in   = 1'b0;
                     bit_index_in = 4'd0;
                  end
               end else begin
                  if ((bit_index_ff == 4'd0) || !in_window) begin
                     parity_acc_in = 1'b0;
                     bit_index_in  = 4'd1;
                  end else if (bit_index_ff < ps2hp_pkg::RX_PARITY_BIT) begin
                     rx_shift_in   = {data_pin, rx_shift_ff[7:1]};
                     parity_acc_in = parity_acc_ff ^ data_pin;
                     bit_index_in  = bit_index_ff + 4'd1;
                  end else if (bit_index_ff == ps2hp_pkg::RX_PARITY_BIT) begin
                     parity_seen_in = data_pin;
                     bit_index_in   = bit_index_ff + 4'd1;
                  end else begin
                     bit_index_in = 4'd0;
                     frame.store  = parity_seen_ff != parity_acc_ff;
                  end
               end
            end
            ps2hp_pkg::CMD_SEND: begin
               sending_in    = 1'b1;
               bit_index_in  = 4'd0;
               parity_acc_in = 1'b0;
               tx_shift_in   = tx_byte;
               line_level_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_index_ff   <= 4'd0;
         parity_acc_ff  <= 1'b0;
         parity_seen_ff <= 1'b0;
         sending_ff     <= 1'b0;
         line_level_ff  <= 1'b1;
      end else begin
         bit_index_ff   <= bit_index_in;
         parity_acc_ff  <= parity_acc_in;
         parity_seen_ff <= parity_seen_in;
         sending_ff     <= sending_in;
         line_level_ff  <= line_level_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_shift_ff <= rx_shift_in;
      tx_shift_ff <= tx_shift_in;
   end

endmodule
`default_nettype wire

// ===== rtl/ps2hp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "ps2_host_side_port_unit_macros.svh"
module ps2hp_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ps2hp_pkg::queue_op_type     op,
   output      ps2hp_pkg::queue_status_type status,
   output      logic [7:0]                  rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [AW:0]   occupancy;

   function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
      wrap_next = (p == LAST_SLOT) ? '0 : p + AW'(1);
   endfunction

   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      status.rd_valid = 1'b0;
      status.stored   = 1'b0;
      status.dropped  = 1'b0;
      if (op.clear) begin
         head_in = '0;
         tail_in = '0;
      end else if (op.pop) begin
         if (head_ff != tail_ff) begin
            status.rd_valid = 1'b1;
            tail_in         = wrap_next(tail_ff);
         end
      end else if (op.store) begin
         head_in       = wrap_next(head_ff);
         status.stored = 1'b1;
         if (head_in == tail_ff) begin
            tail_in        = wrap_next(tail_ff);
            status.dropped = 1'b1;
         end
      end
      if (head_in >= tail_in) begin
         occupancy = {1'b0, head_in} - {1'b0, tail_in};
      end else begin
         occupancy = {1'b0, head_in} + DEPTH_W - {1'b0, tail_in};
      end
      status.fill = 4'(occupancy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   ps2hp_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (op.store),
      .waddr (head_ff),
      .wdata (op.data),
      .re    (status.rd_valid),
      .raddr (tail_ff),
      .rdata (rd_data)
   );

   `PS2HP_ASSERT_NEXT(a_clear_empties, clock, reset, op.clear, head_ff == tail_ff)
   `PS2HP_ASSERT_NEXT(a_store_not_empty, clock, reset, op.store && !op.clear && !op.pop,
                      head_ff != tail_ff)
   `PS2HP_ASSERT_NEXT(a_pop_advances, clock, reset, status.rd_valid,
                      tail_ff != $past(tail_ff))

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;

   typedef struct packed {
      logic       data_drive;
      logic       busy_res;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic [3:0] fill_count;
      logic       frame_stored;
      logic       dropped_oldest;
   } port_result_type;

   class port_scoreboard;
      bit [7:0]        win_min;
      bit [7:0]        win_max;
      bit [3:0]        bit_pos;
      bit [7:0]        rx_bits;
      bit              par_acc;
      bit              par_seen;
      bit              tx_active;
      bit [7:0]        tx_bits;
      bit              line_level;
      bit [7:0]        rx_ring [16];
      bit [3:0]        ring_head;
      bit [3:0]        ring_tail;
      port_result_type pending_results [$];
      int              n_items;
      int              n_stored;
      int              n_dropped;
      int              n_popped;
      int              n_sends;
      int              n_checked;
      int              n_mismatch;
      int              n_unexpected;
      int              n_left;
      int              n_reported;

      function new();
         win_min = ps2hp_pkg::MIN_INTERVAL_RESET;
         win_max = ps2hp_pkg::MAX_INTERVAL_RESET;
         line_level = 1'b1;
      endfunction

      function void set_window(ps2hp_pkg::csr_index_type idx, bit [7:0] value);
         if (idx == ps2hp_pkg::CSR_MIN_INTERVAL) begin
            win_min = value;
         end else begin
            win_max = value;
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void note_request(ps2hp_pkg::cmd_type cmd, bit pin, bit [7:0] ticks,
                                 bit [7:0] txb);
         port_result_type r;
         r = '0;
         case (cmd)
            ps2hp_pkg::CMD_EDGE: begin
               if (tx_active) begin
                  if (bit_pos < 4'd8) begin
                     line_level = tx_bits[0];
                     par_acc ^= tx_bits[0];
                     tx_bits = tx_bits >> 1;
                     bit_pos++;
                  end else if (bit_pos == ps2hp_pkg::TX_PARITY_BIT) begin
                     line_level = ~par_acc;
                     bit_pos++;
                  end else if (bit_pos == ps2hp_pkg::TX_STOP_BIT) begin
                     line_level = 1'b1;
                     bit_pos++;
                  end else begin
                     tx_active = 1'b0;
                     bit_pos = 4'd0;
                  end
               end else if (bit_pos == 4'd0 || ticks < win_min || ticks > win_max) begin
                  par_acc = 1'b0;
                  bit_pos = 4'd1;
               end else if (bit_pos < ps2hp_pkg::RX_PARITY_BIT) begin
                  rx_bits = {pin, rx_bits[7:1]};
                  par_acc ^= pin;
                  bit_pos++;
               end else if (bit_pos == ps2hp_pkg::RX_PARITY_BIT) begin
                  par_seen = pin;
                  bit_pos++;
               end else begin
                  bit_pos = 4'd0;
                  if (par_seen != par_acc) begin
                     rx_ring[ring_head] = rx_bits;
                     ring_head++;
                     r.frame_stored = 1'b1;
                     n_stored++;
                     if (ring_head == ring_tail) begin
                        ring_tail++;
                        r.dropped_oldest = 1'b1;
                        n_dropped++;
                     end
                  end
               end
            end
            ps2hp_pkg::CMD_SEND: begin
               tx_active = 1'b1;
               bit_pos = 4'd0;
               par_acc = 1'b0;
               tx_bits = txb;
               line_level = 1'b0;
               n_sends++;
            end
            ps2hp_pkg::CMD_POP: begin
               if (ring_head != ring_tail) begin
                  r.rx_byte = rx_ring[ring_tail];
                  r.rx_valid = 1'b1;
                  ring_tail++;
                  n_popped++;
               end
            end
            default: begin
               ring_head = 4'd0;
               ring_tail = 4'd0;
            end
         endcase
         r.data_drive = line_level;
         r.busy_res = tx_active;
         r.fill_count = ring_head - ring_tail;
         pending_results.push_back(r);
         n_items++;
      endfunction

      function void check_response(port_result_type got);
         port_result_type want;
         if (pending_results.size() == 0) begin
            n_unexpected++;
            if (n_reported < 10) begin
               $display("unexpected rsp transfer: drive=%0b busy=%0b byte=%02h valid=%0b",
                        got.data_drive, got.busy_res, got.rx_byte, got.rx_valid);
            end
            n_reported++;
            return;
         end
         want = pending_results.pop_front();
         if (want.data_drive !== got.data_drive || want.busy_res !== got.busy_res ||
             want.rx_byte !== got.rx_byte || want.rx_valid !== got.rx_valid ||
             want.fill_count !== got.fill_count || want.frame_stored !== got.frame_stored ||
             want.dropped_oldest !== got.dropped_oldest) begin
            n_mismatch++;
            if (n_reported < 10) begin
               $display("result %0d expected drive=%0b busy=%0b byte=%02h valid=%0b fill=%0d %s",
                        n_checked, want.data_drive, want.busy_res, want.rx_byte,
                        want.rx_valid, want.fill_count,
                        $sformatf("stored=%0b dropped=%0b", want.frame_stored,
                                  want.dropped_oldest));
               $display("result %0d actual   drive=%0b busy=%0b byte=%02h valid=%0b fill=%0d %s",
                        n_checked, got.data_drive, got.busy_res, got.rx_byte,
                        got.rx_valid, got.fill_count,
                        $sformatf("stored=%0b dropped=%0b", got.frame_stored,
                                  got.dropped_oldest));
            end
            n_reported++;
         end
         n_checked++;
      endfunction

      function void close();
         n_left = pending_results.size();
         if (n_left != 0) begin
            $display("%0d expected results never arrived", n_left);
         end
      endfunction

      function int failures();
         return n_mismatch + n_unexpected + n_left;
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   ps2hp_pkg::csr_index_type csr_index;
   logic [7:0]               csr_wdata;
   int                       sender_idle_pct;
   int                       receiver_stall_pct;
   int                       hold_cycles;
   int                       window_settings;
   port_result_type          observed;
   port_scoreboard           sb;

   ps2hp_req_if req_bus ();
   ps2hp_rsp_if rsp_bus ();

   ps2_host_side_port_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // The receiver holds ready low for the whole of a hold request before it
   // goes back to random stalling.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_bus.ready = ($urandom_range(99, 0) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         observed.data_drive = rsp_bus.data_drive;
         observed.busy_res = rsp_bus.busy_res;
         observed.rx_byte = rsp_bus.rx_byte;
         observed.rx_valid = rsp_bus.rx_valid;
         observed.fill_count = rsp_bus.fill_count;
         observed.frame_stored = rsp_bus.frame_stored;
         observed.dropped_oldest = rsp_bus.dropped_oldest;
         sb.check_response(observed);
      end
   end

   task automatic send_item(ps2hp_pkg::cmd_type cmd, bit pin, bit [7:0] ticks,
                            bit [7:0] txb);
      @(negedge clock);
      while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.cmd = cmd;
      req_bus.data_pin = pin;
      req_bus.interval_ticks = ticks;
      req_bus.tx_byte = txb;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(cmd, pin, ticks, txb);
   endtask

   function automatic bit [7:0] ticks_inside();
      int lo;
      int hi;
      lo = sb.win_min;
      hi = sb.win_max;
      if (lo <= hi) begin
         return 8'($urandom_range(hi, lo));
      end
      return 8'($urandom_range(255, 0));
   endfunction

   function automatic bit [7:0] ticks_outside();
      int lo;
      int hi;
      lo = sb.win_min;
      hi = sb.win_max;
      if (lo > 0 && (hi == 255 || $urandom_range(1, 0) == 1)) begin
         return 8'($urandom_range(lo - 1, 0));
      end else if (hi < 255) begin
         return 8'($urandom_range(255, hi + 1));
      end
      return 8'($urandom_range(255, 0));
   endfunction

   // A start edge outside the window realigns the frame whatever receive state a
   // broken frame left behind, though not while a send is still in progress.
   task automatic send_frame(bit [7:0] data, bit good_parity, bit broken);
      int cut;
      bit pin;
      bit [7:0] ticks;
      cut = broken ? int'($urandom_range(10, 1)) : 11;
      for (int k = 0; k < 11; k++) begin
         if (k == 0) begin
            pin = 1'($urandom_range(1, 0));
            ticks = ($urandom_range(4, 0) != 0) ? ticks_outside() : ticks_inside();
         end else begin
            if (k <= 8) begin
               pin = data[k - 1];
            end else if (k == 9) begin
               pin = good_parity ? ~^data : ^data;
            end else begin
               pin = 1'($urandom_range(1, 0));
            end
            ticks = (k == cut) ? 8'($urandom_range(255, 0)) : ticks_inside();
         end
         send_item(ps2hp_pkg::CMD_EDGE, pin, ticks, 8'($urandom_range(255, 0)));
      end
   endtask

   task automatic transmit(bit [7:0] data, int edges);
      send_item(ps2hp_pkg::CMD_SEND, 1'($urandom_range(1, 0)),
                8'($urandom_range(255, 0)), data);
      repeat (edges) begin
         send_item(ps2hp_pkg::CMD_EDGE, 1'($urandom_range(1, 0)),
                   8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
      end
   endtask

   task automatic run_random(int count);
      int target;
      int pick;
      target = sb.n_items + count;
      while (sb.n_items < target) begin
         pick = int'($urandom_range(99, 0));
         if (pick < 45) begin
            send_frame(8'($urandom_range(255, 0)), $urandom_range(9, 0) != 0, 1'b0);
         end else if (pick < 52) begin
            send_frame(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), 1'b1);
         end else if (pick < 67) begin
            repeat ($urandom_range(2, 1)) begin
               send_item(ps2hp_pkg::CMD_POP, 1'($urandom_range(1, 0)),
                         8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
            end
         end else if (pick < 78) begin
            transmit(8'($urandom_range(255, 0)), 11);
         end else if (pick < 82) begin
            transmit(8'($urandom_range(255, 0)), int'($urandom_range(10, 0)));
         end else if (pick < 84) begin
            send_item(ps2hp_pkg::CMD_CLEAR, 1'($urandom_range(1, 0)),
                      8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
         end else begin
            send_item(ps2hp_pkg::cmd_type'($urandom_range(3, 0)), 1'($urandom_range(1, 0)),
                      8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
         end
      end
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(ps2hp_pkg::csr_index_type idx, bit [7:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_window(idx, value);
   endtask

   initial begin
      bit [7:0] lo;
      bit [7:0] hi;
      sb = new();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_cycles = 0;
      window_settings = 1;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = ps2hp_pkg::CSR_MIN_INTERVAL;
      csr_wdata = 8'h00;
      req_bus.valid = 1'b0;
      req_bus.cmd = ps2hp_pkg::CMD_EDGE;
      req_bus.data_pin = 1'b0;
      req_bus.interval_ticks = 8'h00;
      req_bus.tx_byte = 8'h00;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(ps2hp_pkg::CMD_POP, 1'b0, 8'h00, 8'h00);
      send_item(ps2hp_pkg::CMD_SEND, 1'b1, 8'hFF, 8'h00);
      repeat (2) send_item(ps2hp_pkg::CMD_EDGE, 1'b0, 8'h00, 8'hFF);
      send_item(ps2hp_pkg::CMD_SEND, 1'b0, 8'h00, 8'hFF);
      repeat (11) send_item(ps2hp_pkg::CMD_EDGE, 1'b1, 8'hFF, 8'h00);
      send_item(ps2hp_pkg::CMD_EDGE, 1'b1, 8'd200, 8'h00);
      send_item(ps2hp_pkg::CMD_EDGE, 1'b0, ps2hp_pkg::MIN_INTERVAL_RESET, 8'h00);
      send_item(ps2hp_pkg::CMD_EDGE, 1'b1, ps2hp_pkg::MAX_INTERVAL_RESET, 8'h00);
      send_item(ps2hp_pkg::CMD_EDGE, 1'b1, ps2hp_pkg::MIN_INTERVAL_RESET - 8'd1, 8'h00);
      send_item(ps2hp_pkg::CMD_EDGE, 1'b0, ps2hp_pkg::MAX_INTERVAL_RESET + 8'd1, 8'h00);
      send_item(ps2hp_pkg::CMD_CLEAR, 1'b1, 8'hFF, 8'hFF);

      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         case (ph)
            0, 7: begin
               lo = ps2hp_pkg::MIN_INTERVAL_RESET;
               hi = ps2hp_pkg::MAX_INTERVAL_RESET;
            end
            1: begin
               lo = 8'd0;
               hi = 8'd255;
            end
            2: begin
               lo = 8'd255;
               hi = 8'd0;
            end
            3: begin
               lo = 8'd0;
               hi = 8'd0;
            end
            4: begin
               lo = 8'd255;
               hi = 8'd255;
            end
            default: begin
               lo = 8'($urandom_range(120, 0));
               hi = 8'(lo + $urandom_range(135, 0));
            end
         endcase
         write_window(ps2hp_pkg::CSR_MIN_INTERVAL, lo);
         write_window(ps2hp_pkg::CSR_MAX_INTERVAL, hi);
         window_settings++;
         case (ph % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 55;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 55;
            end
            default: begin
               sender_idle_pct = 26;
               receiver_stall_pct = 26;
            end
         endcase
         if (ph == 4) begin
            hold_cycles = 300;
         end
         run_random(250);
      end

      wait_drained();
      sb.close();
      $display("Checked %0d results from %0d requests across %0d window settings.",
               sb.n_checked, sb.n_items, window_settings);
      $display("Frames stored %0d, oldest dropped %0d, bytes popped %0d, sends %0d.",
               sb.n_stored, sb.n_dropped, sb.n_popped, sb.n_sends);
      if (sb.failures() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
